@@ design/skt_pkg.sv @@
// Shared types for the sorted key table: request and status codes, control structs.
`default_nettype none
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int BKT_W = 8;
  localparam logic [BKT_W-1:0] LAST_BUCKET = 8'hFF;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_ADD_UNIQ = 2'd1,
    REQ_SORT     = 2'd2,
    REQ_SEARCH   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_MISS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DUP_PRIME,
    S_DUP_RUN,
    S_APPEND,
    S_SRT_RD_I,
    S_SRT_LATCH,
    S_SRT_CMP,
    S_SRT_PLACE,
    S_IDX_PRIME,
    S_IDX_RUN,
    S_SRC_BKT,
    S_SRC_RUN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    req_load;
    logic    hold_rd;
    logic    mem_wr;
    logic    wr_shift;
    logic    bkt_wr;
    logic    found_cap;
    logic    out_load;
    logic    res_ok;
    status_t res_status;
  } skt_cmd_t;

  typedef struct packed {
    req_t             req_type;
    logic             key_eq;
    logic             key_gt;
    logic [BKT_W-1:0] top_byte;
    logic             out_busy;
  } skt_sts_t;

endpackage
`default_nettype wire

@@ design/skt_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface skt_in_if;
  import skt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] entry_value;
  modport source (output valid, req_type, key, entry_value, input ready);
  modport sink   (input valid, req_type, key, entry_value, output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [1:0]       status;
  logic [VAL_W-1:0] found_value;
  modport source (output valid, ok, status, found_value, input ready);
  modport sink   (input valid, ok, status, found_value, output ready);
endinterface
`default_nettype wire

@@ design/skt_dp.sv @@
// Datapath: key/value memories, bucket index memories, request and result registers.
`default_nettype none
module skt_dp import skt_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  skt_in_if.sink                 in_ch,
  skt_out_if.source              out_ch,
  input  wire skt_cmd_t          cmd,
  input  wire logic [AW-1:0]     rd_addr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BKT_W-1:0]  bkt_idx,
  input  wire logic [AW-1:0]     bkt_wstart,
  input  wire logic [CW-1:0]     bkt_wsize,
  output skt_sts_t               sts,
  output logic [AW-1:0]          bkt_start,
  output logic [CW-1:0]          bkt_size
);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [AW-1:0]    start_mem [1 << BKT_W];
  logic [CW-1:0]    size_mem [1 << BKT_W];

  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic [1:0]       req_type_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;
  logic [VAL_W-1:0] found_r;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [1:0]       out_status_r;
  logic [VAL_W-1:0] out_found_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      key_mem[wr_addr] <= cmd.wr_shift ? key_rd_r : req_key_r;
      val_mem[wr_addr] <= cmd.wr_shift ? val_rd_r : req_val_r;
    end
    key_rd_r <= key_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
  end

  // bucket lookup always follows the held request key
  always_ff @(posedge clk) begin
    if (cmd.bkt_wr) begin
      start_mem[bkt_idx] <= bkt_wstart;
      size_mem[bkt_idx]  <= bkt_wsize;
    end
    bkt_start <= start_mem[req_key_r[KEY_W-1 -: BKT_W]];
    bkt_size  <= size_mem[req_key_r[KEY_W-1 -: BKT_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type_r <= in_ch.req_type;
      req_key_r  <= in_ch.key;
      req_val_r  <= in_ch.entry_value;
    end else if (cmd.hold_rd) begin
      req_key_r <= key_rd_r;
      req_val_r <= val_rd_r;
    end
    if (cmd.req_load) begin
      found_r <= '0;
    end else if (cmd.found_cap) begin
      found_r <= val_rd_r;
    end
    if (cmd.out_load) begin
      out_ok_r     <= cmd.res_ok;
      out_status_r <= cmd.res_status;
      out_found_r  <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_value = out_found_r;

  assign sts.req_type = req_t'(req_type_r);
  assign sts.key_eq   = (key_rd_r == req_key_r);
  assign sts.key_gt   = (key_rd_r > req_key_r);
  assign sts.top_byte = key_rd_r[KEY_W-1 -: BKT_W];
  assign sts.out_busy = out_valid_r && !out_ch.ready;

endmodule
`default_nettype wire

@@ design/skt_ctrl.sv @@
// Controller: request sequencing, scan/sort/index counters and result codes.
`default_nettype none
module skt_ctrl import skt_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_rdy,
  input  wire skt_sts_t          sts,
  input  wire logic [AW-1:0]     bkt_start,
  input  wire logic [CW-1:0]     bkt_size,
  output skt_cmd_t               cmd,
  output logic [AW-1:0]          rd_addr,
  output logic [AW-1:0]          wr_addr,
  output logic [BKT_W-1:0]       bkt_idx,
  output logic [AW-1:0]          bkt_wstart,
  output logic [CW-1:0]          bkt_wsize
);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [BKT_W-1:0] b_r, b_nxt;
  logic             indexed_r, indexed_nxt;
  logic             res_ok_r, res_ok_nxt;
  status_t          res_status_r, res_status_nxt;

  logic [CW-1:0] inc_i, dec_i, inc_j, dec_j, dec2_j, size_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      i_r          <= '0;
      j_r          <= '0;
      n_r          <= '0;
      b_r          <= '0;
      indexed_r    <= 1'b0;
      res_ok_r     <= 1'b0;
      res_status_r <= STS_DONE;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      n_r          <= n_nxt;
      b_r          <= b_nxt;
      indexed_r    <= indexed_nxt;
      res_ok_r     <= res_ok_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign inc_i    = i_r + CW'(1);
  assign dec_i    = i_r - CW'(1);
  assign inc_j    = j_r + CW'(1);
  assign dec_j    = j_r - CW'(1);
  assign dec2_j   = j_r - CW'(2);
  // bucket memory holds nothing meaningful before the first index build
  assign size_eff = indexed_r ? bkt_size : '0;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    b_nxt          = b_r;
    indexed_nxt    = indexed_r;
    res_ok_nxt     = res_ok_r;
    res_status_nxt = res_status_r;
    cmd            = '0;
    cmd.res_ok     = res_ok_r;
    cmd.res_status = res_status_r;
    in_rdy         = 1'b0;
    rd_addr        = i_r[AW-1:0];
    wr_addr        = j_r[AW-1:0];
    bkt_idx        = b_r;
    bkt_wstart     = (n_r != '0) ? j_r[AW-1:0] : '0;
    bkt_wsize      = n_r;

    case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        i_nxt = '0;
        case (sts.req_type)
          REQ_ADD:      state_nxt = S_APPEND;
          REQ_ADD_UNIQ: state_nxt = S_DUP_PRIME;
          REQ_SORT: begin
            i_nxt = CW'(1);
            if (cnt_r == '0) begin
              res_ok_nxt     = 1'b1;
              res_status_nxt = STS_DONE;
              state_nxt      = S_RESP;
            end else if (cnt_r == CW'(1)) begin
              state_nxt = S_IDX_PRIME;
            end else begin
              state_nxt = S_SRT_RD_I;
            end
          end
          REQ_SEARCH:   state_nxt = S_SRC_BKT;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_DUP_PRIME: begin
        state_nxt = S_DUP_RUN;
      end
      S_DUP_RUN: begin
        rd_addr = inc_i[AW-1:0];
        if (i_r == cnt_r) begin
          state_nxt = S_APPEND;
        end else if (sts.key_eq) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = STS_DUP;
          state_nxt      = S_RESP;
        end else begin
          i_nxt = inc_i;
        end
      end
      S_APPEND: begin
        wr_addr = cnt_r[AW-1:0];
        if (cnt_r == CW'(CAPACITY)) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = STS_FULL;
        end else begin
          cmd.mem_wr     = 1'b1;
          cnt_nxt        = cnt_r + CW'(1);
          res_ok_nxt     = 1'b1;
          res_status_nxt = STS_DONE;
        end
        state_nxt = S_RESP;
      end
      S_SRT_RD_I: begin
        state_nxt = S_SRT_LATCH;
      end
      S_SRT_LATCH: begin
        cmd.hold_rd = 1'b1;
        j_nxt       = i_r;
        rd_addr     = dec_i[AW-1:0];
        state_nxt   = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        // shift the greater entry up one slot and look one further down
        if (sts.key_gt) begin
          cmd.mem_wr   = 1'b1;
          cmd.wr_shift = 1'b1;
          j_nxt        = dec_j;
          rd_addr      = dec2_j[AW-1:0];
          if (j_r == CW'(1)) begin
            state_nxt = S_SRT_PLACE;
          end
        end else begin
          state_nxt = S_SRT_PLACE;
        end
      end
      S_SRT_PLACE: begin
        cmd.mem_wr = 1'b1;
        if (inc_i == cnt_r) begin
          state_nxt = S_IDX_PRIME;
        end else begin
          i_nxt     = inc_i;
          state_nxt = S_SRT_RD_I;
        end
      end
      S_IDX_PRIME: begin
        i_nxt     = '0;
        j_nxt     = '0;
        n_nxt     = '0;
        b_nxt     = '0;
        rd_addr   = '0;
        state_nxt = S_IDX_RUN;
      end
      S_IDX_RUN: begin
        if (i_r < cnt_r && sts.top_byte == b_r) begin
          n_nxt   = n_r + CW'(1);
          i_nxt   = inc_i;
          rd_addr = inc_i[AW-1:0];
        end else begin
          cmd.bkt_wr = 1'b1;
          if (b_r == LAST_BUCKET) begin
            indexed_nxt    = 1'b1;
            res_ok_nxt     = 1'b1;
            res_status_nxt = STS_DONE;
            state_nxt      = S_RESP;
          end else begin
            b_nxt = b_r + BKT_W'(1);
            j_nxt = i_r;
            n_nxt = '0;
          end
        end
      end
      S_SRC_BKT: begin
        i_nxt   = '0;
        j_nxt   = CW'(bkt_start);
        n_nxt   = size_eff;
        rd_addr = bkt_start;
        if (size_eff == '0) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = STS_MISS;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SRC_RUN;
        end
      end
      S_SRC_RUN: begin
        rd_addr = inc_j[AW-1:0];
        if (sts.key_eq) begin
          cmd.found_cap  = 1'b1;
          res_ok_nxt     = 1'b1;
          res_status_nxt = STS_DONE;
          state_nxt      = S_RESP;
        end else if (sts.key_gt || inc_i == n_r) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = STS_MISS;
          state_nxt      = S_RESP;
        end else begin
          i_nxt = inc_i;
          j_nxt = inc_j;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a stalled transfer");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_rdy && in_valid) |=> state_r == S_DISPATCH)
    else $error("accepted request not dispatched");
  a_sort_j: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRT_CMP |-> (j_r <= i_r && j_r != '0 && i_r < cnt_r))
    else $error("sort insert position out of range");
`endif

endmodule
`default_nettype wire

@@ design/sorted_key_table_prefix_index.sv @@
// Sorted key/value table with a 256-bucket index on the top key byte.
// One request at a time: the next transfer is taken in the cycle after the result loads.
// Add: appends at the end of the table. Add-or-skip: linear duplicate scan, then append.
// Search: scans the key's bucket, one stored key compared per cycle.
// Sort: insertion sort, then an index pass over the sorted entries.
// Sync active-low reset empties table and index.
`default_nettype none
module sorted_key_table_prefix_index import skt_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  skt_cmd_t         cmd;
  skt_sts_t         sts;
  logic             in_rdy;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [BKT_W-1:0] bkt_idx;
  logic [AW-1:0]    bkt_wstart;
  logic [CW-1:0]    bkt_wsize;
  logic [AW-1:0]    bkt_start;
  logic [CW-1:0]    bkt_size;

  assign in_ch.ready = in_rdy;

  skt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_rdy     (in_rdy),
    .sts        (sts),
    .bkt_start  (bkt_start),
    .bkt_size   (bkt_size),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .bkt_idx    (bkt_idx),
    .bkt_wstart (bkt_wstart),
    .bkt_wsize  (bkt_wsize)
  );

  skt_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .bkt_idx    (bkt_idx),
    .bkt_wstart (bkt_wstart),
    .bkt_wsize  (bkt_wsize),
    .sts        (sts),
    .bkt_start  (bkt_start),
    .bkt_size   (bkt_size)
  );

endmodule
`default_nettype wire
